@@ hw/rtl/bstep_pkg.sv @@
// ----------------------------------------------------------------------------
// bstep_pkg
// Shared types and constants of the three-axis Bresenham step generator.
// ----------------------------------------------------------------------------
package bstep_pkg;

    localparam int STEP_W   = 16;
    localparam int PERIOD_W = 16;
    localparam int NUM_AXES = 3;

    localparam logic [PERIOD_W-1:0] IDLE_PERIOD_RST = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_STOP   = 2'd1,
        OP_PAUSE  = 2'd2,
        OP_RESUME = 2'd3
    } op_t;

    typedef logic [1:0] axis_t;

    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    typedef logic [1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_ORIENT_X = 2'd0;
    localparam cfg_idx_t CFG_ORIENT_Y = 2'd1;
    localparam cfg_idx_t CFG_ORIENT_Z = 2'd2;
    localparam cfg_idx_t CFG_IDLE_PER = 2'd3;

endpackage

@@ hw/rtl/bstep_seg_decode.sv @@
// ----------------------------------------------------------------------------
// bstep_seg_decode
// Segment decode: step magnitudes with saturation, signs, axis ordering by
// step count and the seed values of the two minor-axis error terms.
// ----------------------------------------------------------------------------
module bstep_seg_decode #(
    parameter int COUNT_WIDTH = 15
) (
    input  logic signed [bstep_pkg::STEP_W-1:0]      steps_x,
    input  logic signed [bstep_pkg::STEP_W-1:0]      steps_y,
    input  logic signed [bstep_pkg::STEP_W-1:0]      steps_z,
    output logic [2:0][COUNT_WIDTH-1:0]              total,
    output logic [2:0]                               negative,
    output logic [2:0]                               nonzero,
    output logic [2:0][1:0]                          order,
    output logic [1:0][COUNT_WIDTH+2:0]              err_seed
);
    import bstep_pkg::*;

    localparam int MAG_W = STEP_W + 1;
    localparam int CMP_W = (COUNT_WIDTH > MAG_W) ? COUNT_WIDTH : MAG_W;
    localparam int ERR_W = COUNT_WIDTH + 3;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [2:0][STEP_W-1:0] raw;
    logic [2:0][MAG_W-1:0]  mag;
    logic [2:0][CMP_W-1:0]  mag_ext;
    logic [ERR_W-1:0]       t0_e;
    logic [ERR_W-1:0]       t1_e;
    logic [ERR_W-1:0]       t2_e;

    assign raw[AXIS_X] = steps_x;
    assign raw[AXIS_Y] = steps_y;
    assign raw[AXIS_Z] = steps_z;

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            negative[a] = raw[a][STEP_W-1];
            nonzero[a]  = (raw[a] != '0);
            mag[a]      = negative[a] ? (MAG_W'(1) << STEP_W) - {1'b0, raw[a]}
                                      : {1'b0, raw[a]};
            mag_ext[a]  = CMP_W'(mag[a]);
            total[a]    = (mag_ext[a] > CMP_W'(COUNT_MAX)) ? COUNT_MAX
                                                           : mag_ext[a][COUNT_WIDTH-1:0];
        end
    end

    // Sort by strict-greater comparison tree; ties fall to the later branch.
    always_comb
    begin
        if (total[AXIS_X] > total[AXIS_Y])
        begin
            if (total[AXIS_X] > total[AXIS_Z])
            begin
                if (total[AXIS_Y] > total[AXIS_Z])
                    order = {AXIS_Z, AXIS_Y, AXIS_X};
                else
                    order = {AXIS_Y, AXIS_Z, AXIS_X};
            end
            else
            begin
                order = {AXIS_Y, AXIS_X, AXIS_Z};
            end
        end
        else
        begin
            if (total[AXIS_Y] > total[AXIS_Z])
            begin
                if (total[AXIS_X] > total[AXIS_Z])
                    order = {AXIS_Z, AXIS_X, AXIS_Y};
                else
                    order = {AXIS_X, AXIS_Z, AXIS_Y};
            end
            else
            begin
                order = {AXIS_X, AXIS_Y, AXIS_Z};
            end
        end
    end

    always_comb
    begin
        t0_e = ERR_W'(total[order[0]]);
        t1_e = ERR_W'(total[order[1]]);
        t2_e = ERR_W'(total[order[2]]);
        err_seed[0] = (t1_e != '0) ? (t1_e << 1) - t0_e : '0;
        err_seed[1] = (t2_e != '0) ? (t2_e << 1) - t0_e : '0;
    end

endmodule

@@ hw/rtl/three_axis_bresenham_stepper_core.sv @@
// ----------------------------------------------------------------------------
// three_axis_bresenham_stepper_core
// Path: an accepted transaction is captured in the input register, then one
//   pass of update logic writes the result register, unless out_ready stalls.
// Throughput: one transaction per cycle unless stalled; one update pass sets it.
// Reset: idle, not paused, motors off, all counts, positions and error terms
//   zero, axis order z, y, x, tick period and idle period 65535.
// ----------------------------------------------------------------------------
module three_axis_bresenham_stepper_core #(
    parameter int COUNT_WIDTH    = 15,
    parameter int POSITION_WIDTH = 32
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [1:0]                               operation,
    input  logic                                     segment_valid,
    input  logic signed [bstep_pkg::STEP_W-1:0]      steps_x,
    input  logic signed [bstep_pkg::STEP_W-1:0]      steps_y,
    input  logic signed [bstep_pkg::STEP_W-1:0]      steps_z,
    input  logic [bstep_pkg::PERIOD_W-1:0]           segment_period,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic                                     pulse_x,
    output logic                                     pulse_y,
    output logic                                     pulse_z,
    output logic                                     dir_x,
    output logic                                     dir_y,
    output logic                                     dir_z,
    output logic                                     enable_x,
    output logic                                     enable_y,
    output logic                                     enable_z,
    output logic                                     is_idle,
    output logic                                     period_update,
    output logic [bstep_pkg::PERIOD_W-1:0]           tick_period,
    input  logic                                     cfg_write,
    input  bstep_pkg::cfg_idx_t                      cfg_index,
    input  logic [bstep_pkg::PERIOD_W-1:0]           cfg_data
);
    import bstep_pkg::*;

    localparam int ERR_W = COUNT_WIDTH + 3;

    // configuration
    logic [2:0]                     orient_reg;
    logic [PERIOD_W-1:0]            idle_period_reg;

    // input stage
    logic                           in_vld_reg;
    op_t                            op_reg;
    logic                           seg_vld_reg;
    logic signed [STEP_W-1:0]       steps_x_reg;
    logic signed [STEP_W-1:0]       steps_y_reg;
    logic signed [STEP_W-1:0]       steps_z_reg;
    logic [PERIOD_W-1:0]            seg_period_reg;

    // block state
    logic                           idle_reg,   idle_next;
    logic                           paused_reg, paused_next;
    logic                           motors_reg, motors_next;
    logic [PERIOD_W-1:0]            period_reg, period_next;
    logic [2:0][COUNT_WIDTH-1:0]    total_reg,  total_next;
    logic [2:0]                     neg_reg,    neg_next;
    logic [2:0][1:0]                order_reg,  order_next;
    logic [1:0][ERR_W-1:0]          err_reg,    err_next;
    logic [COUNT_WIDTH-1:0]         mdc_reg,    mdc_next;
    logic [2:0][POSITION_WIDTH-1:0] pos_reg,    pos_next;

    // result stage
    logic                           out_vld_reg;
    logic [2:0]                     pulse_reg;
    logic [2:0]                     dir_reg;
    logic [2:0]                     enable_reg;
    logic                           is_idle_reg;
    logic                           upd_reg;
    logic [PERIOD_W-1:0]            tick_period_reg;

    logic                           advance;
    logic                           load;
    logic                           run;
    logic                           upd;
    logic [2:0]                     pulse;
    logic [COUNT_WIDTH-1:0]         t0;
    logic [COUNT_WIDTH-1:0]         ts;
    logic [ERR_W-1:0]               t0_e;
    logic [ERR_W-1:0]               ts_e;

    logic [2:0][COUNT_WIDTH-1:0]    seg_total;
    logic [2:0]                     seg_neg;
    logic [2:0]                     seg_nz;
    logic [2:0][1:0]                seg_order;
    logic [1:0][ERR_W-1:0]          seg_err;

    bstep_seg_decode #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seg_decode (
        .steps_x  (steps_x_reg),
        .steps_y  (steps_y_reg),
        .steps_z  (steps_z_reg),
        .total    (seg_total),
        .negative (seg_neg),
        .nonzero  (seg_nz),
        .order    (seg_order),
        .err_seed (seg_err)
    );

    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg      <= '0;
            idle_period_reg <= IDLE_PERIOD_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ORIENT_X: orient_reg[AXIS_X] <= cfg_data[0];
                CFG_ORIENT_Y: orient_reg[AXIS_Y] <= cfg_data[0];
                CFG_ORIENT_Z: orient_reg[AXIS_Z] <= cfg_data[0];
                CFG_IDLE_PER: idle_period_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg         <= op_t'(operation);
            seg_vld_reg    <= segment_valid;
            steps_x_reg    <= steps_x;
            steps_y_reg    <= steps_y;
            steps_z_reg    <= steps_z;
            seg_period_reg <= segment_period;
        end
    end

    always_comb
    begin
        load        = 1'b0;
        run         = 1'b0;
        upd         = 1'b0;
        pulse       = '0;
        t0          = '0;
        ts          = '0;
        t0_e        = '0;
        ts_e        = '0;
        idle_next   = idle_reg;
        paused_next = paused_reg;
        motors_next = motors_reg;
        period_next = period_reg;
        total_next  = total_reg;
        neg_next    = neg_reg;
        order_next  = order_reg;
        err_next    = err_reg;
        mdc_next    = mdc_reg;
        pos_next    = pos_reg;

        unique case (op_reg)
            OP_STOP:
            begin
                paused_next = 1'b1;
                motors_next = 1'b0;
                total_next  = '0;
                mdc_next    = '0;
                idle_next   = 1'b1;
                period_next = idle_period_reg;
                upd         = 1'b1;
            end
            OP_PAUSE:
            begin
                paused_next = 1'b1;
                motors_next = 1'b0;
            end
            OP_RESUME:
            begin
                paused_next = 1'b0;
                motors_next = 1'b1;
            end
            OP_TICK:
            begin
                if (!paused_reg)
                begin
                    run = 1'b1;
                    if (idle_reg)
                    begin
                        if (seg_vld_reg)
                        begin
                            load        = 1'b1;
                            idle_next   = 1'b0;
                            motors_next = 1'b1;
                            upd         = 1'b1;
                        end
                        else
                        begin
                            run = 1'b0;
                        end
                    end
                    else if (mdc_reg == total_reg[order_reg[0]])
                    begin
                        if (seg_vld_reg)
                        begin
                            load        = 1'b1;
                            motors_next = 1'b1;
                            upd         = 1'b1;
                        end
                        else
                        begin
                            period_next = idle_period_reg;
                            upd         = 1'b1;
                            motors_next = 1'b0;
                            idle_next   = 1'b1;
                            run         = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (load)
        begin
            total_next = seg_total;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                // zero-step axis keeps its previous direction
                if (seg_nz[a])
                    neg_next[a] = seg_neg[a];
            end
            order_next  = seg_order;
            err_next    = seg_err;
            mdc_next    = '0;
            period_next = seg_period_reg;
        end

        if (run && (mdc_next < total_next[order_next[0]]))
        begin
            t0   = total_next[order_next[0]];
            t0_e = ERR_W'(t0);
            pulse[order_next[0]] = 1'b1;
            for (int k = 0; k < 2; k++)
            begin
                ts   = total_next[order_next[k+1]];
                ts_e = ERR_W'(ts);
                if (ts != '0)
                begin
                    if (!err_next[k][ERR_W-1])
                    begin
                        err_next[k] = err_next[k] + ((ts_e - t0_e) << 1);
                        pulse[order_next[k+1]] = 1'b1;
                    end
                    else
                    begin
                        err_next[k] = err_next[k] + (ts_e << 1);
                    end
                end
            end
            mdc_next = mdc_next + COUNT_WIDTH'(1);
        end

        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (pulse[a])
                pos_next[a] = neg_next[a] ? pos_reg[a] - POSITION_WIDTH'(1)
                                          : pos_reg[a] + POSITION_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg   <= 1'b1;
            paused_reg <= 1'b0;
            motors_reg <= 1'b0;
            period_reg <= IDLE_PERIOD_RST;
            total_reg  <= '0;
            neg_reg    <= '0;
            order_reg  <= {AXIS_X, AXIS_Y, AXIS_Z};
            err_reg    <= '0;
            mdc_reg    <= '0;
            pos_reg    <= '0;
        end
        else if (advance)
        begin
            idle_reg   <= idle_next;
            paused_reg <= paused_next;
            motors_reg <= motors_next;
            period_reg <= period_next;
            total_reg  <= total_next;
            neg_reg    <= neg_next;
            order_reg  <= order_next;
            err_reg    <= err_next;
            mdc_reg    <= mdc_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pulse_reg       <= pulse;
            dir_reg         <= neg_next ^ orient_reg;
            for (int a = 0; a < NUM_AXES; a++)
                enable_reg[a] <= motors_next && (total_next[a] != '0);
            is_idle_reg     <= idle_next;
            upd_reg         <= upd;
            tick_period_reg <= period_next;
        end
    end

    assign out_valid     = out_vld_reg;
    assign pulse_x       = pulse_reg[AXIS_X];
    assign pulse_y       = pulse_reg[AXIS_Y];
    assign pulse_z       = pulse_reg[AXIS_Z];
    assign dir_x         = dir_reg[AXIS_X];
    assign dir_y         = dir_reg[AXIS_Y];
    assign dir_z         = dir_reg[AXIS_Z];
    assign enable_x      = enable_reg[AXIS_X];
    assign enable_y      = enable_reg[AXIS_Y];
    assign enable_z      = enable_reg[AXIS_Z];
    assign is_idle       = is_idle_reg;
    assign period_update = upd_reg;
    assign tick_period   = tick_period_reg;

    // major axis never runs past its total
    a_major_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mdc_reg <= total_reg[order_reg[0]])
        else $error("major step count exceeds major total");

    a_idle_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_idle |-> !pulse_x && !pulse_y && !pulse_z)
        else $error("step pulse reported while idle");

    a_pulse_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (pulse_x || pulse_y || pulse_z) |->
            (!pulse_x || enable_x) && (!pulse_y || enable_y) && (!pulse_z || enable_z))
        else $error("step pulse on a disabled axis");

endmodule
